[sv/cfv_pkg.sv]
// ============================================================================
// cfv_pkg
// Shared types and constants of the command frame validator.
// ============================================================================
package cfv_pkg;

    // Frame layout.
    localparam int HEADER_BYTES    = 15;
    localparam int MIN_FRAME_BYTES = 16;
    localparam int TOTAL_END_POS   = 4;   // first byte after the declared total
    localparam int CMD_END_POS     = 7;   // first byte after the command text
    localparam int ID_LEN_END_POS  = 11;  // first byte after the id length
    localparam int LAST_HEADER_POS = HEADER_BYTES - 1;
    localparam int NUMERIC_MIN_LEN = 8;

    // Byte position counter: saturates at all ones.
    localparam int IDX_W = 33;
    // Positions compared against sums of two 32-bit lengths need two more bits.
    localparam int POS_W = IDX_W + 1;

    // Command text, first byte in the low bits.
    localparam logic [23:0] CMD_SET = 24'h746573;
    localparam logic [23:0] CMD_GET = 24'h746567;

    // Decoupling queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ROLE_HEADER  = 3'd0,
        ROLE_ID      = 3'd1,
        ROLE_TERM    = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_EXCESS  = 3'd4
    } role_t;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_SET     = 2'd1,
        KIND_GET     = 2'd2
    } kind_t;

    // Individual frame checks, evaluated by the front on every beat.
    typedef struct packed {
        logic not_saturated;
        logic long_enough;
        logic size_match;
        logic id_nonzero;
        logic sum_match;
        logic term_ok;
        logic cmd_set;
        logic cmd_get;
        logic payload_ge8;
    } checks_t;

    // One classified beat as it travels through the queue.
    typedef struct packed {
        logic [7:0]  data;
        role_t       role;
        logic        last;
        checks_t     checks;
        logic [31:0] id_len;
        logic [31:0] pay_len;
    } item_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic  empty;
        item_t head;
    } queue_status_t;

endpackage

[sv/cfv_front.sv]
// ============================================================================
// cfv_front
// Accepts frame bytes, assembles the header and classifies each byte.
// ============================================================================
module cfv_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     data_byte,
    input  logic           last_byte,
    input  logic           queue_full,
    output logic           push,
    output cfv_pkg::item_t push_item
);

    logic [cfv_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]               total_reg, total_next;
    logic [23:0]               cmd_reg, cmd_next;
    logic [31:0]               idl_reg, idl_next;
    logic [31:0]               pl_reg, pl_next;
    logic                      term_ok_reg, term_ok_next;
    // Position of the id terminator and first position past the payload.
    logic [cfv_pkg::POS_W-1:0] term_pos_reg, term_pos_next;
    logic [cfv_pkg::POS_W-1:0] end_pos_reg, end_pos_next;

    logic                      in_header;
    logic [cfv_pkg::POS_W-1:0] pos;
    logic [cfv_pkg::POS_W-1:0] size;
    cfv_pkg::role_t            role;
    logic                      accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    assign in_header = idx_reg < cfv_pkg::IDX_W'(cfv_pkg::HEADER_BYTES);
    assign pos       = {1'b0, idx_reg};
    assign size      = pos + cfv_pkg::POS_W'(1);

    // Header capture; lengths are visible on the same beat they complete.
    always_comb
    begin
        total_next    = total_reg;
        cmd_next      = cmd_reg;
        idl_next      = idl_reg;
        pl_next       = pl_reg;
        term_pos_next = term_pos_reg;
        end_pos_next  = end_pos_reg;
        if (in_header)
        begin
            case (idx_reg[3:0])
                4'd0:    total_next[7:0]   = data_byte;
                4'd1:    total_next[15:8]  = data_byte;
                4'd2:    total_next[23:16] = data_byte;
                4'd3:    total_next[31:24] = data_byte;
                4'd4:    cmd_next[7:0]     = data_byte;
                4'd5:    cmd_next[15:8]    = data_byte;
                4'd6:    cmd_next[23:16]   = data_byte;
                4'd7:    idl_next[7:0]     = data_byte;
                4'd8:    idl_next[15:8]    = data_byte;
                4'd9:    idl_next[23:16]   = data_byte;
                4'd10:   idl_next[31:24]   = data_byte;
                4'd11:   pl_next[7:0]      = data_byte;
                4'd12:   pl_next[15:8]     = data_byte;
                4'd13:   pl_next[23:16]    = data_byte;
                4'd14:   pl_next[31:24]    = data_byte;
                default: total_next        = total_reg;
            endcase
            // On the last header byte both lengths are known: the region
            // boundaries are worked out once here and reused for the body.
            if (idx_reg[3:0] == 4'(cfv_pkg::LAST_HEADER_POS))
            begin
                term_pos_next = {2'b00, idl_reg}
                              + cfv_pkg::POS_W'(cfv_pkg::LAST_HEADER_POS);
                end_pos_next  = {2'b00, idl_reg} + {2'b00, pl_next}
                              + cfv_pkg::POS_W'(cfv_pkg::HEADER_BYTES);
            end
        end
    end

    // Byte role. A zero id length puts the terminator at the last header
    // position, so the id regions never match and the body is payload.
    always_comb
    begin
        if (in_header)
            role = cfv_pkg::ROLE_HEADER;
        else if (pos < term_pos_reg)
            role = cfv_pkg::ROLE_ID;
        else if (pos == term_pos_reg)
            role = cfv_pkg::ROLE_TERM;
        else if (pos < end_pos_reg)
            role = cfv_pkg::ROLE_PAYLOAD;
        else
            role = cfv_pkg::ROLE_EXCESS;
    end

    assign term_ok_next = term_ok_reg
                       || (role == cfv_pkg::ROLE_TERM && data_byte == 8'h00);

    always_comb
    begin
        idx_next = idx_reg;
        if (idx_reg != {cfv_pkg::IDX_W{1'b1}})
            idx_next = idx_reg + cfv_pkg::IDX_W'(1);
    end

    always_comb
    begin
        push_item.data                 = data_byte;
        push_item.role                 = role;
        push_item.last                 = last_byte;
        push_item.id_len               = idl_next;
        push_item.pay_len              = pl_next;
        push_item.checks.not_saturated = idx_reg != {cfv_pkg::IDX_W{1'b1}};
        push_item.checks.long_enough   =
            size >= cfv_pkg::POS_W'(cfv_pkg::MIN_FRAME_BYTES);
        push_item.checks.size_match    = size == {2'b00, total_next};
        push_item.checks.id_nonzero    = idl_next != 32'd0;
        // Only meaningful once the header is complete, which the length
        // check already demands.
        push_item.checks.sum_match     = size == end_pos_reg;
        push_item.checks.term_ok       = term_ok_next;
        push_item.checks.cmd_set       = cmd_next == cfv_pkg::CMD_SET;
        push_item.checks.cmd_get       = cmd_next == cfv_pkg::CMD_GET;
        push_item.checks.payload_ge8   = pl_next >= 32'(cfv_pkg::NUMERIC_MIN_LEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            total_reg    <= '0;
            cmd_reg      <= '0;
            idl_reg      <= '0;
            pl_reg       <= '0;
            term_ok_reg  <= 1'b0;
            term_pos_reg <= '0;
            end_pos_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                idx_reg      <= '0;
                total_reg    <= '0;
                cmd_reg      <= '0;
                idl_reg      <= '0;
                pl_reg       <= '0;
                term_ok_reg  <= 1'b0;
                term_pos_reg <= '0;
                end_pos_reg  <= '0;
            end
            else
            begin
                idx_reg      <= idx_next;
                total_reg    <= total_next;
                cmd_reg      <= cmd_next;
                idl_reg      <= idl_next;
                pl_reg       <= pl_next;
                term_ok_reg  <= term_ok_next;
                term_pos_reg <= term_pos_next;
                end_pos_reg  <= end_pos_next;
            end
        end
    end

endmodule

[sv/cfv_queue.sv]
// ============================================================================
// cfv_queue
// Short FIFO of classified beats between the front and the back end.
// ============================================================================
module cfv_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cfv_pkg::item_t         push_item,
    input  logic                   pop,
    output logic                   full,
    output cfv_pkg::queue_status_t status
);

    cfv_pkg::item_t                  mem_reg [cfv_pkg::QUEUE_DEPTH];
    logic [cfv_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cfv_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full         = count_reg == cfv_pkg::QUEUE_CNT_W'(cfv_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign status.head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + cfv_pkg::QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - cfv_pkg::QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + cfv_pkg::QUEUE_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + cfv_pkg::QUEUE_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[sv/cfv_back.sv]
// ============================================================================
// cfv_back
// Combines the frame checks at frame end and holds the result register.
// ============================================================================
module cfv_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfv_pkg::queue_status_t status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             byte_out,
    output logic [2:0]             byte_role,
    output logic                   frame_end,
    output logic                   frame_valid,
    output logic [1:0]             command_kind,
    output logic [31:0]            id_length_out,
    output logic [31:0]            payload_length_out,
    output logic                   numeric_set
);

    logic            out_valid_reg;
    logic [7:0]      data_reg;
    cfv_pkg::role_t  role_reg;
    logic            last_reg;
    logic            valid_reg;
    cfv_pkg::kind_t  kind_reg;
    logic [31:0]     idl_reg;
    logic [31:0]     pl_reg;
    logic            numeric_reg;

    cfv_pkg::checks_t chk;
    logic             valid_next;
    cfv_pkg::kind_t   kind_next;
    logic             numeric_next;

    assign pop = !status.empty && (!out_valid_reg || out_ready);
    assign chk = status.head.checks;

    always_comb
    begin
        valid_next = status.head.last && chk.not_saturated && chk.long_enough
                  && chk.size_match && chk.id_nonzero && chk.sum_match
                  && chk.term_ok;
        if (!valid_next)
            kind_next = cfv_pkg::KIND_UNKNOWN;
        else if (chk.cmd_set)
            kind_next = cfv_pkg::KIND_SET;
        else if (chk.cmd_get)
            kind_next = cfv_pkg::KIND_GET;
        else
            kind_next = cfv_pkg::KIND_UNKNOWN;
        numeric_next = kind_next == cfv_pkg::KIND_SET && chk.payload_ge8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg    <= status.head.data;
            role_reg    <= status.head.role;
            last_reg    <= status.head.last;
            valid_reg   <= valid_next;
            kind_reg    <= kind_next;
            idl_reg     <= status.head.id_len;
            pl_reg      <= status.head.pay_len;
            numeric_reg <= numeric_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign byte_out           = data_reg;
    assign byte_role          = 3'(role_reg);
    assign frame_end          = last_reg;
    assign frame_valid        = valid_reg;
    assign command_kind       = 2'(kind_reg);
    assign id_length_out      = idl_reg;
    assign payload_length_out = pl_reg;
    assign numeric_set        = numeric_reg;

endmodule

[sv/command_frame_validator_unit.sv]
// ============================================================================
// command_frame_validator_unit
// Byte-wide command frame validator with a decoupled classify/report path.
// ============================================================================
// The input channel (in_valid/in_ready, data_byte, last_byte) takes one frame
// byte per beat; last_byte marks the final byte of a frame. The output
// channel (out_valid/out_ready) returns exactly one result beat per input
// beat, in order: the byte, its role in the frame and, on the final byte,
// the validity verdict, the command kind and the numeric-set flag. The
// declared lengths are reported on every beat as assembled so far.
// An accepted beat is written into the queue and from there into the output
// register; the block sustains one beat per cycle while out_ready stays high.
// The front end assembles the header and classifies each byte against
// region boundaries that it computes once, on the last header byte; the
// back end folds the per-byte checks into the verdict. A four-entry queue
// sits between them, so in_ready stays high while the receiver stalls
// until four beats are waiting behind the output register.
// Reset clears the byte position, the header fields and the queue; the
// output register comes up empty. After each final byte the frame state
// returns to its reset values, ready for the next frame.
// ============================================================================
module command_frame_validator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte_out,
    output logic [2:0]  byte_role,
    output logic        frame_end,
    output logic        frame_valid,
    output logic [1:0]  command_kind,
    output logic [31:0] id_length_out,
    output logic [31:0] payload_length_out,
    output logic        numeric_set
);

    // Front to queue.
    logic                   push;
    cfv_pkg::item_t         push_item;
    logic                   queue_full;

    // Queue to back end.
    cfv_pkg::queue_status_t queue_status;
    logic                   pop;

    // The front end owns the frame state and accepts a beat whenever the
    // queue has a free entry.
    cfv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    cfv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .status    (queue_status)
    );

    // The back end drains the queue into its output register whenever that
    // register is empty or being taken in the same cycle.
    cfv_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .status             (queue_status),
        .pop                (pop),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .byte_out           (byte_out),
        .byte_role          (byte_role),
        .frame_end          (frame_end),
        .frame_valid        (frame_valid),
        .command_kind       (command_kind),
        .id_length_out      (id_length_out),
        .payload_length_out (payload_length_out),
        .numeric_set        (numeric_set)
    );

endmodule
